// ===== rtl/stq_pkg.sv =====
// stq_pkg: shared types and codes for the sorted timer queue
// used by stq_ctrl, stq_datapath, sorted_timer_queue and stq_checker
package stq_pkg;

  localparam int SLOT_W = 6;
  localparam logic [SLOT_W-1:0] NO_LINK = 6'd63;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
  localparam logic [SLOT_W-1:0] TTS_RESET = 6'd32;

  typedef enum logic [2:0] {
    OP_ALLOC      = 3'd0,
    OP_FREE       = 3'd1,
    OP_BIND       = 3'd2,
    OP_ARM        = 3'd3,
    OP_TICK       = 3'd4,
    OP_CANCEL     = 3'd5,
    OP_CANCEL_ALL = 3'd6,
    OP_SET_MARK   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_RUN   = 2'd2
  } slot_st_t;

  typedef enum logic [2:0] {
    KIND_ALLOC   = 3'd0,
    KIND_CANCEL  = 3'd1,
    KIND_POST    = 3'd2,
    KIND_SUMMARY = 3'd3,
    KIND_ACK     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    RD_CUR  = 2'd0,
    RD_HEAD = 2'd1,
    RD_TGT  = 2'd2
  } rd_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;
    logic     walk_init;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     advance;
    logic     unlink_fix;
    logic     ins_link_s;
    logic     ins_link_prev;
    logic     set_due;
    logic     cnt_inc;
    logic     wr_dl;
    logic     wr_bind;
    logic     wr_mark;
    logic     st_wr;
    slot_st_t st_val;
    logic     tgt_clr;
    logic     tgt_inc;
    logic     expire;
    logic     ts_set;
    logic     emit;
    kind_t    emit_kind;
    logic     emit_ok;
  } stq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_t      op;
    logic     tgt_ok;
    slot_st_t st_tgt;
    logic     mark_tgt;
    logic     cur_ok;
    logic     cur_eq_tgt;
    logic     cur_eq_tts;
    logic     dl_lt_d;
    logic     dl_le_cnt;
    logic     due_le_cnt;
    logic     own_eq_fifo;
    logic     out_free;
  } stq_stat_t;

endpackage

// ===== rtl/stq_datapath.sv =====
// stq_datapath: slot state, timer memories, list pointers, tick count and result register
// depends on stq_pkg; driven by stq_ctrl commands
module stq_datapath #(
  parameter int NUM_SLOTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  stq_pkg::stq_cmd_t  cmd,
  output stq_pkg::stq_stat_t stat,
  input  logic [2:0]         in_op,
  input  logic [79:0]        in_data,
  input  logic               cfg_wr_en,
  input  logic [5:0]         cfg_wr_data,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata,
  output logic [2:0]         out_tuser,
  output logic               out_tlast
);
  import stq_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] NSLOT = SLOT_W'(NUM_SLOTS);

  // latched item
  op_t               op_r;
  logic [SLOT_W-1:0] tgt_r;
  logic [7:0]        fifo_r;
  logic [31:0]       pay_r;
  logic [31:0]       d_r;
  logic              mark_in_r;

  // timer state
  logic [31:0]       cnt_r;
  logic [31:0]       due_r;
  logic [SLOT_W-1:0] head_r;
  logic [SLOT_W-1:0] cur_r;
  logic [SLOT_W-1:0] prev_r;
  logic              ts_r;
  logic [SLOT_W-1:0] tts_r;
  slot_st_t          status_r [NUM_SLOTS];
  logic              mark_r [NUM_SLOTS];

  // memories and registered read data
  logic [SLOT_W-1:0] link_mem [NUM_SLOTS];
  logic [31:0]       dl_mem [NUM_SLOTS];
  logic [7:0]        own_mem [NUM_SLOTS];
  logic [31:0]       val_mem [NUM_SLOTS];
  logic [SLOT_W-1:0] link_rd_r;
  logic [31:0]       dl_rd_r;
  logic [7:0]        own_rd_r;
  logic [31:0]       val_rd_r;

  // result register
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [4:0]        out_slot_r;
  logic              out_ok_r;
  logic [7:0]        out_fifo_r;
  logic [31:0]       out_val_r;
  logic              out_ts_r;
  logic              out_last_r;

  logic [IDX_W-1:0]  tgt_idx, cur_idx, prev_idx, rd_idx, link_widx;
  logic              tgt_ok, cur_ok, prev_ok, head_ok;
  logic [SLOT_W-1:0] rd_addr, link_wd;
  logic              link_we;
  logic [NUM_SLOTS-1:0] free_vec, lowest;
  logic [SLOT_W-1:0] free_idx;
  logic              free_found, alloc_do, out_free;

  assign tgt_idx  = tgt_r[IDX_W-1:0];
  assign cur_idx  = cur_r[IDX_W-1:0];
  assign prev_idx = prev_r[IDX_W-1:0];
  assign tgt_ok   = tgt_r < NSLOT;
  assign cur_ok   = cur_r < NSLOT;
  assign prev_ok  = prev_r < NSLOT;
  assign head_ok  = head_r < NSLOT;
  assign out_free = !out_valid_r || out_tready;

  // read address select
  always_comb begin
    unique case (cmd.rd_sel)
      RD_HEAD: rd_addr = head_r;
      RD_TGT:  rd_addr = tgt_r;
      default: rd_addr = cur_r;
    endcase
  end
  assign rd_idx = rd_addr[IDX_W-1:0];

  // lowest free slot: isolate lowest set bit, then encode
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      free_vec[i] = (status_r[i] == ST_FREE);
    end
    lowest = free_vec & (~free_vec + {{(NUM_SLOTS-1){1'b0}}, 1'b1});
    free_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (lowest[i]) free_idx = free_idx | SLOT_W'(i);
    end
  end
  assign free_found = |free_vec;
  assign alloc_do   = cmd.emit && (cmd.emit_kind == KIND_ALLOC) && free_found;

  // latch item fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op_t'(in_op);
      tgt_r     <= {1'b0, in_data[4:0]};
      fifo_r    <= in_data[12:5];
      pay_r     <= in_data[44:13];
      d_r       <= cnt_r + in_data[76:45];
      mark_in_r <= in_data[77];
    end else if (cmd.tgt_clr) begin
      tgt_r <= '0;
    end else if (cmd.tgt_inc) begin
      tgt_r <= tgt_r + 1'b1;
    end
  end

  // list pointers, tick count, next deadline, task switch flag, config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NO_LINK;
      cur_r  <= NO_LINK;
      prev_r <= NO_LINK;
      cnt_r  <= '0;
      due_r  <= ALL_ONES;
      ts_r   <= 1'b0;
      tts_r  <= TTS_RESET;
    end else begin
      if (cfg_wr_en) tts_r <= cfg_wr_data;
      if (cmd.cnt_inc) cnt_r <= cnt_r + 32'd1;
      if (cmd.set_due) due_r <= head_ok ? dl_rd_r : ALL_ONES;
      if (cmd.load) ts_r <= 1'b0;
      else if (cmd.ts_set) ts_r <= 1'b1;
      priority if (cmd.walk_init) begin
        prev_r <= NO_LINK;
        cur_r  <= head_r;
      end else if (cmd.advance) begin
        prev_r <= cur_r;
        cur_r  <= link_rd_r;
      end else if (cmd.expire) begin
        cur_r  <= link_rd_r;
        head_r <= link_rd_r;
      end else if (cmd.unlink_fix) begin
        if (!prev_ok) head_r <= link_rd_r;
      end else if (cmd.ins_link_prev) begin
        if (!prev_ok) head_r <= tgt_r;
      end
    end
  end

  // slot status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) status_r[i] <= ST_FREE;
    end else begin
      if (cmd.st_wr) status_r[tgt_idx] <= cmd.st_val;
      if (cmd.expire) status_r[cur_idx] <= ST_ALLOC;
      if (alloc_do) status_r[free_idx[IDX_W-1:0]] <= ST_ALLOC;
    end
  end

  // auto-cancel marks
  always_ff @(posedge clk) begin
    if (cmd.wr_mark) mark_r[tgt_idx] <= mark_in_r;
    if (alloc_do) mark_r[free_idx[IDX_W-1:0]] <= 1'b0;
  end

  // link memory write port
  always_comb begin
    link_we = (cmd.unlink_fix && prev_ok) || cmd.ins_link_s ||
              (cmd.ins_link_prev && prev_ok);
    link_widx = cmd.ins_link_s ? tgt_idx : prev_idx;
    if (cmd.unlink_fix) link_wd = link_rd_r;
    else if (cmd.ins_link_s) link_wd = cur_r;
    else link_wd = tgt_r;
  end

  // memories
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_widx] <= link_wd;
    if (cmd.wr_dl) dl_mem[tgt_idx] <= d_r;
    if (cmd.wr_bind) begin
      own_mem[tgt_idx] <= fifo_r;
      val_mem[tgt_idx] <= pay_r;
    end
    if (cmd.rd_en) begin
      link_rd_r <= link_mem[rd_idx];
      dl_rd_r   <= dl_mem[rd_idx];
      own_rd_r  <= own_mem[rd_idx];
      val_rd_r  <= val_mem[rd_idx];
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  // result register fields
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= cmd.emit_kind;
      out_slot_r <= '0;
      out_ok_r   <= 1'b0;
      out_fifo_r <= '0;
      out_val_r  <= '0;
      out_ts_r   <= 1'b0;
      out_last_r <= 1'b1;
      unique case (cmd.emit_kind)
        KIND_ALLOC: begin
          out_slot_r <= free_found ? free_idx[4:0] : 5'd0;
          out_ok_r   <= free_found;
        end
        KIND_CANCEL: begin
          out_slot_r <= tgt_r[4:0];
          out_ok_r   <= cmd.emit_ok;
        end
        KIND_POST: begin
          out_slot_r <= cur_r[4:0];
          out_fifo_r <= own_rd_r;
          out_val_r  <= val_rd_r;
          out_last_r <= 1'b0;
        end
        KIND_SUMMARY: out_ts_r <= ts_r;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_ts_r, out_val_r, out_fifo_r, out_ok_r, out_slot_r};

  // status to controller
  always_comb begin
    stat.op          = op_r;
    stat.tgt_ok      = tgt_ok;
    stat.st_tgt      = tgt_ok ? status_r[tgt_idx] : ST_FREE;
    stat.mark_tgt    = tgt_ok && mark_r[tgt_idx];
    stat.cur_ok      = cur_ok;
    stat.cur_eq_tgt  = (cur_r == tgt_r);
    stat.cur_eq_tts  = (cur_r == tts_r);
    stat.dl_lt_d     = (dl_rd_r < d_r);
    stat.dl_le_cnt   = (dl_rd_r <= cnt_r);
    stat.due_le_cnt  = (due_r <= cnt_r);
    stat.own_eq_fifo = (own_rd_r == fifo_r);
    stat.out_free    = out_free;
  end

endmodule

// ===== rtl/stq_ctrl.sv =====
// stq_ctrl: sequencer for list walks, expiry, cancel sweep and result emission
// depends on stq_pkg; drives stq_datapath through stq_cmd_t
module stq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  stq_pkg::stq_stat_t stat,
  output stq_pkg::stq_cmd_t  cmd
);
  import stq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_U_CHK, S_U_USE, S_U_DONE, S_ARM_SET,
    S_I_CHK, S_I_USE, S_I_LINK_S, S_I_LINK_P, S_T_CHK, S_T_RD, S_T_USE,
    S_CA_CHK, S_CA_USE, S_CA_NEXT, S_REFRESH, S_REFRESH_SET, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   ok_r, ok_nxt;

  // state and cancel answer flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ok_r    <= ok_nxt;
    end
  end

  // next state and commands
  always_comb begin
    cmd       = '0;
    cmd.st_val    = ST_FREE;
    cmd.rd_sel    = RD_CUR;
    cmd.emit_kind = KIND_ACK;
    state_nxt = state_r;
    ok_nxt    = ok_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // no item is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        ok_nxt    = 1'b0;
        state_nxt = S_EMIT;
        unique case (stat.op)
          OP_ALLOC: ;
          OP_FREE: begin
            if (stat.tgt_ok && stat.st_tgt == ST_RUN) begin
              cmd.walk_init = 1'b1;
              state_nxt     = S_U_CHK;
            end else if (stat.tgt_ok) begin
              cmd.st_wr  = 1'b1;
              cmd.st_val = ST_FREE;
            end
          end
          OP_BIND: cmd.wr_bind = stat.tgt_ok;
          OP_ARM: begin
            if (stat.tgt_ok && stat.st_tgt == ST_RUN) begin
              cmd.walk_init = 1'b1;
              state_nxt     = S_U_CHK;
            end else if (stat.tgt_ok && stat.st_tgt != ST_FREE) begin
              state_nxt = S_ARM_SET;
            end
          end
          OP_TICK: begin
            cmd.cnt_inc = 1'b1;
            state_nxt   = S_T_CHK;
          end
          OP_CANCEL: begin
            if (stat.tgt_ok && stat.st_tgt == ST_RUN) begin
              ok_nxt        = 1'b1;
              cmd.walk_init = 1'b1;
              state_nxt     = S_U_CHK;
            end
          end
          OP_CANCEL_ALL: begin
            cmd.tgt_clr = 1'b1;
            state_nxt   = S_CA_CHK;
          end
          OP_SET_MARK: cmd.wr_mark = stat.tgt_ok;
          default: ;
        endcase
      end
      // unlink walk: find target, splice its successor in
      S_U_CHK: begin
        if (stat.cur_ok) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_U_USE;
        end else begin
          state_nxt = S_U_DONE;
        end
      end
      S_U_USE: begin
        if (stat.cur_eq_tgt) begin
          cmd.unlink_fix = 1'b1;
          state_nxt      = S_U_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_U_CHK;
        end
      end
      S_U_DONE: begin
        priority case (stat.op)
          OP_FREE: begin
            cmd.st_wr = 1'b1;
            cmd.st_val = ST_FREE;
            state_nxt = S_REFRESH;
          end
          OP_CANCEL: begin
            cmd.st_wr = 1'b1;
            cmd.st_val = ST_ALLOC;
            state_nxt = S_REFRESH;
          end
          OP_ARM: state_nxt = S_ARM_SET;
          OP_CANCEL_ALL: begin
            cmd.st_wr = 1'b1;
            cmd.st_val = ST_FREE;
            state_nxt = S_CA_NEXT;
          end
          default: state_nxt = S_REFRESH;
        endcase
      end
      // insert walk: stop at first deadline not below the new one
      S_ARM_SET: begin
        cmd.wr_dl     = 1'b1;
        cmd.st_wr     = 1'b1;
        cmd.st_val    = ST_RUN;
        cmd.walk_init = 1'b1;
        state_nxt     = S_I_CHK;
      end
      S_I_CHK: begin
        if (stat.cur_ok) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_I_USE;
        end else begin
          state_nxt = S_I_LINK_S;
        end
      end
      S_I_USE: begin
        if (stat.dl_lt_d) begin
          cmd.advance = 1'b1;
          state_nxt   = S_I_CHK;
        end else begin
          state_nxt = S_I_LINK_S;
        end
      end
      S_I_LINK_S: begin
        cmd.ins_link_s = 1'b1;
        state_nxt      = S_I_LINK_P;
      end
      S_I_LINK_P: begin
        cmd.ins_link_prev = 1'b1;
        state_nxt         = S_REFRESH;
      end
      // tick: pop due slots from the head
      S_T_CHK: begin
        if (stat.due_le_cnt) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_T_RD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_T_RD: begin
        if (stat.cur_ok) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_T_USE;
        end else begin
          state_nxt = S_REFRESH;
        end
      end
      S_T_USE: begin
        if (!stat.dl_le_cnt) begin
          state_nxt = S_REFRESH;
        end else if (stat.cur_eq_tts) begin
          cmd.expire = 1'b1;
          cmd.ts_set = 1'b1;
          state_nxt  = S_T_RD;
        end else if (stat.out_free) begin
          cmd.expire    = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_POST;
          state_nxt     = S_T_RD;
        end
      end
      // cancel_all sweep over every slot
      S_CA_CHK: begin
        if (!stat.tgt_ok) begin
          state_nxt = S_REFRESH;
        end else if (stat.st_tgt != ST_FREE && stat.mark_tgt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_TGT;
          state_nxt  = S_CA_USE;
        end else begin
          cmd.tgt_inc = 1'b1;
        end
      end
      S_CA_USE: begin
        state_nxt = S_CA_NEXT;
        if (stat.own_eq_fifo) begin
          if (stat.st_tgt == ST_RUN) begin
            cmd.walk_init = 1'b1;
            state_nxt     = S_U_CHK;
          end else begin
            cmd.st_wr  = 1'b1;
            cmd.st_val = ST_FREE;
          end
        end
      end
      S_CA_NEXT: begin
        cmd.tgt_inc = 1'b1;
        state_nxt   = S_CA_CHK;
      end
      // reload next deadline from the head
      S_REFRESH: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_HEAD;
        state_nxt  = S_REFRESH_SET;
      end
      S_REFRESH_SET: begin
        cmd.set_due = 1'b1;
        state_nxt   = S_EMIT;
      end
      // closing result of the item
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.emit_ok = ok_r;
          priority case (stat.op)
            OP_ALLOC:  cmd.emit_kind = KIND_ALLOC;
            OP_CANCEL: cmd.emit_kind = KIND_CANCEL;
            OP_TICK:   cmd.emit_kind = KIND_SUMMARY;
            default:   cmd.emit_kind = KIND_ACK;
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/sorted_timer_queue.sv =====
// sorted_timer_queue: top level of the sorted timer queue
// instantiates stq_ctrl and stq_datapath; uses stq_pkg
//
// Usage: one command item enters on the in_ stream (operation in in_tuser).
// Every command returns one result item; a tick returns one expiry post per
// expired slot other than the task timer slot (tlast low), then a summary
// (tlast high). Results leave through a registered out_ stream; out_tuser
// carries the result kind. cfg_wr_en/cfg_wr_data set the task timer slot;
// write only when idle.
// Timing: one item at a time. Free, cancel and re-arm of a running slot walk the
// list to unlink it; arm walks the list to its insert point; a due tick pops each
// expired slot from the head; cancel_all scans every slot, reads each marked slot
// and walks the list for each running match. The walk cost comes from one read
// port with registered read data.
// in_tready is high only between items; an item may be taken while the last
// result still waits. A stalled receiver holds the pending result and the
// sequencer waits for it before the next result.
// Reset: all slots free, list empty, tick count zero, next deadline all ones,
// task timer slot 32 (none); no item is taken while reset is held.
module sorted_timer_queue #(
  parameter int NUM_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // slot[4:0], fifo_id[12:5], payload[44:13],
                                  // delay[76:45], autocancel[77], zero[79:78]
  input  logic [2:0]  in_tuser,   // operation[2:0]
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // timer_slot[4:0], ok[5], dest_fifo[13:6],
                                  // posted_value[45:14], switch_req[46], zero[47]
  output logic [2:0]  out_tuser,  // result_kind[2:0]
  output logic        out_tlast
);
  import stq_pkg::*;

  stq_cmd_t  cmd;
  stq_stat_t stat;

  // sequencer
  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and result register
  stq_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (in_tuser),
    .in_data     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== rtl/stq_checker.sv =====
// stq_checker: port-level assertions for sorted_timer_queue, bound to the top level
// depends on stq_pkg
module stq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import stq_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // expiry posts never close an item
  a_post_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_POST |-> !out_tlast)
    else $error("expiry post marked last");

  // every other result closes its item
  a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_POST |-> out_tlast)
    else $error("closing result not marked last");

  // summary carries only the task switch flag
  a_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SUMMARY |-> out_tdata[45:0] == 46'd0)
    else $error("tick summary carries stray fields");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.*);

// ===== dv/tb_sorted_timer_queue.sv =====
// tb_sorted_timer_queue: self-checking bench for the sorted timer queue
// needs stq_pkg and sorted_timer_queue; predicts every result item in-bench
`timescale 1ns / 1ps

module tb_sorted_timer_queue;
  import stq_pkg::*;

  localparam int SLOTS = 32;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    op_t         op;
    logic [4:0]  slot;
    logic [7:0]  fifo;
    logic [31:0] pay;
    logic [31:0] dly;
    logic        mark;
  } timer_cmd_t;

  typedef struct {
    kind_t       kind;
    logic [4:0]  slot;
    logic        ok;
    logic [7:0]  fifo;
    logic [31:0] val;
    logic        ts;
    logic        last;
  } timer_res_t;

  typedef struct {
    timer_cmd_t cmd;
    bit         typed;
    kind_t      kind;
    logic [4:0] slot;
    logic       ok;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // slot[4:0], fifo_id[12:5], payload[44:13], delay[76:45],
                           // autocancel[77], zero[79:78]
  logic [2:0]  in_tuser;   // operation[2:0]
  logic        cfg_wr_en;
  logic [5:0]  cfg_wr_data;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // timer_slot[4:0], ok[5], dest_fifo[13:6], posted_value[45:14],
                           // switch_req[46], zero[47]
  logic [2:0]  out_tuser;  // result_kind[2:0]
  logic        out_tlast;

  sorted_timer_queue #(.NUM_SLOTS(SLOTS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // shadow timer state
  slot_st_t    tq_status [SLOTS];
  logic        tq_mark [SLOTS];
  logic [7:0]  tq_owner [SLOTS];
  logic [31:0] tq_value [SLOTS];
  logic [31:0] tq_deadline [SLOTS];
  int          tq_link [SLOTS];
  bit          tq_bound [SLOTS];
  int          tq_head;
  logic [31:0] tq_count;
  logic [31:0] tq_next_due;
  int          tq_task_slot;

  timer_res_t pending_results[$];
  int errors = 0;
  int tx_idle_pct;
  int rx_stall_pct;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --- predictor ---
  function automatic void refresh_next_due();
    tq_next_due = (tq_head < SLOTS) ? tq_deadline[tq_head] : ALL_ONES;
  endfunction

  function automatic void unlink_timer(int s);
    int prev = -1;
    int cur = tq_head;
    int steps = 0;
    while (cur < SLOTS && steps <= SLOTS) begin
      if (cur == s) begin
        if (prev >= 0) tq_link[prev] = tq_link[cur];
        else tq_head = tq_link[cur];
        break;
      end
      prev = cur;
      cur = tq_link[cur];
      steps++;
    end
    refresh_next_due();
  endfunction

  function automatic void insert_timer(int s);
    int prev = -1;
    int cur = tq_head;
    int steps = 0;
    while (cur < SLOTS && steps <= SLOTS && tq_deadline[cur] < tq_deadline[s]) begin
      prev = cur;
      cur = tq_link[cur];
      steps++;
    end
    tq_link[s] = (cur < SLOTS) ? cur : int'(NO_LINK);
    if (prev >= 0) tq_link[prev] = s;
    else tq_head = s;
    refresh_next_due();
  endfunction

  function automatic bit stop_timer(int s);
    if (tq_status[s] != ST_RUN) return 1'b0;
    unlink_timer(s);
    tq_status[s] = ST_ALLOC;
    return 1'b1;
  endfunction

  function automatic void push_result(kind_t k, int s, logic ok, logic [7:0] f,
                                      logic [31:0] v, logic ts, logic last);
    timer_res_t r;
    r.kind = k;
    r.slot = s[4:0];
    r.ok = ok;
    r.fifo = f;
    r.val = v;
    r.ts = ts;
    r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_timer_op(timer_cmd_t c);
    int s = int'(c.slot);
    int h;
    int n = 0;
    logic ts = 1'b0;
    bit ok;
    case (c.op)
      OP_ALLOC: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tq_status[i] == ST_FREE) begin
            tq_status[i] = ST_ALLOC;
            tq_mark[i] = 1'b0;
            push_result(KIND_ALLOC, i, 1'b1, 8'd0, 32'd0, 1'b0, 1'b1);
            return;
          end
        end
        push_result(KIND_ALLOC, 0, 1'b0, 8'd0, 32'd0, 1'b0, 1'b1);
        return;
      end
      OP_FREE: begin
        ok = stop_timer(s);
        tq_status[s] = ST_FREE;
      end
      OP_BIND: begin
        tq_owner[s] = c.fifo;
        tq_value[s] = c.pay;
        tq_bound[s] = 1'b1;
      end
      OP_ARM: begin
        if (tq_status[s] != ST_FREE) begin
          ok = stop_timer(s);
          tq_deadline[s] = tq_count + c.dly;
          tq_status[s] = ST_RUN;
          insert_timer(s);
        end
      end
      OP_TICK: begin
        tq_count++;
        if (tq_next_due <= tq_count) begin
          while (tq_head < SLOTS && tq_deadline[tq_head] <= tq_count && n < SLOTS) begin
            h = tq_head;
            tq_status[h] = ST_ALLOC;
            tq_head = tq_link[h];
            if (h == tq_task_slot) ts = 1'b1;
            else begin
              push_result(KIND_POST, h, 1'b0, tq_owner[h], tq_value[h], 1'b0, 1'b0);
              n++;
            end
          end
          refresh_next_due();
        end
        push_result(KIND_SUMMARY, 0, 1'b0, 8'd0, 32'd0, ts, 1'b1);
        return;
      end
      OP_CANCEL: begin
        ok = stop_timer(s);
        push_result(KIND_CANCEL, s, ok, 8'd0, 32'd0, 1'b0, 1'b1);
        return;
      end
      OP_CANCEL_ALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tq_status[i] != ST_FREE && tq_mark[i] && tq_owner[i] == c.fifo) begin
            ok = stop_timer(i);
            tq_status[i] = ST_FREE;
          end
        end
      end
      default: tq_mark[s] = c.mark;
    endcase
    push_result(KIND_ACK, 0, 1'b0, 8'd0, 32'd0, 1'b0, 1'b1);
  endfunction

  // --- stimulus ---
  function automatic int pick_slot();
    int start = $urandom_range(SLOTS - 1);
    if ($urandom_range(99) < 70) begin
      for (int i = 0; i < SLOTS; i++)
        if (tq_status[(start + i) % SLOTS] != ST_FREE) return (start + i) % SLOTS;
    end
    return start;
  endfunction

  function automatic timer_cmd_t random_timer_cmd();
    timer_cmd_t c;
    int w = $urandom_range(99);
    int t;
    c.slot = 5'(pick_slot());
    c.fifo = ($urandom_range(99) < 80) ? 8'($urandom_range(3)) : 8'($urandom);
    c.pay = $urandom;
    c.mark = 1'($urandom_range(1));
    t = $urandom_range(99);
    c.dly = (t < 60) ? $urandom_range(4) : (t < 85) ? $urandom_range(40) : $urandom;
    if (w < 12) c.op = OP_ALLOC;
    else if (w < 18) c.op = OP_FREE;
    else if (w < 30) c.op = OP_BIND;
    else if (w < 52) c.op = OP_ARM;
    else if (w < 77) c.op = OP_TICK;
    else if (w < 85) c.op = OP_CANCEL;
    else if (w < 90) c.op = OP_CANCEL_ALL;
    else c.op = OP_SET_MARK;
    // storage never written must not be read: arm or mark only bound slots
    if ((c.op == OP_ARM || (c.op == OP_SET_MARK && c.mark)) && !tq_bound[c.slot])
      c.op = OP_BIND;
    if (c.op == OP_CANCEL_ALL && $urandom_range(99) < 70 && tq_bound[c.slot])
      c.fifo = tq_owner[c.slot];
    return c;
  endfunction

  // present one item and wait for it to be taken
  task automatic send_cmd(timer_cmd_t c);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c.op;
    in_tdata <= {2'b00, c.mark, c.dly, c.pay, c.fifo, c.slot};
    do @(posedge clk); while (!in_tready);
    predict_timer_op(c);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_task_slot(logic [5:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tq_task_slot = int'(v);
  endtask

  // --- receiver ---
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      out_tready <= !(rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
    end
  end

  // --- result checker ---
  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    timer_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result_kind: expected none, got %0d", out_tuser);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("result_kind", e.kind, out_tuser);
        check_field("timer_slot", e.slot, out_tdata[4:0]);
        check_field("ok", e.ok, out_tdata[5]);
        check_field("dest_fifo", e.fifo, out_tdata[13:6]);
        check_field("posted_value", e.val, out_tdata[45:14]);
        check_field("switch_req", e.ts, out_tdata[46]);
        check_field("last", e.last, out_tlast);
      end
    end
  end

  // --- watchdog on cycles without any handshake ---
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_sorted_timer_queue: FAIL");
      $finish;
    end
  end

  // --- main sequence ---
  dir_row_t dir_rows[22];
  logic [5:0] task_slots[5];
  int rx_modes[5];
  int tx_modes[5];
  initial begin
    timer_res_t r;
    timer_cmd_t c;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_ALLOC;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tq_status[i] = ST_FREE;
      tq_mark[i] = 1'b0;
      tq_owner[i] = '0;
      tq_value[i] = '0;
      tq_deadline[i] = '0;
      tq_link[i] = 0;
      tq_bound[i] = 1'b0;
    end
    tq_head = int'(NO_LINK);
    tq_count = '0;
    tq_next_due = ALL_ONES;
    tq_task_slot = int'(TTS_RESET);

    // op, slot, fifo, payload, delay, mark; typed answer where obvious
    dir_rows = '{
      '{'{OP_TICK, 5'd0, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b1, KIND_SUMMARY, 5'd0, 1'b0},
      '{'{OP_CANCEL, 5'd0, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b1, KIND_CANCEL, 5'd0, 1'b0},
      '{'{OP_ALLOC, 5'd0, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b1, KIND_ALLOC, 5'd0, 1'b1},
      '{'{OP_ALLOC, 5'd0, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b1, KIND_ALLOC, 5'd1, 1'b1},
      '{'{OP_BIND, 5'd0, 8'hff, 32'h7fffffff, 32'h0, 1'b0}, 1'b1, KIND_ACK, 5'd0, 1'b0},
      '{'{OP_BIND, 5'd1, 8'h00, 32'h80000000, 32'h0, 1'b0}, 1'b1, KIND_ACK, 5'd0, 1'b0},
      '{'{OP_ARM, 5'd0, 8'h00, 32'h0, 32'd2, 1'b0}, 1'b0, KIND_ACK, 5'd0, 1'b0},
      // equal deadline goes ahead
      '{'{OP_ARM, 5'd1, 8'h00, 32'h0, 32'd2, 1'b0}, 1'b0, KIND_ACK, 5'd0, 1'b0},
      // arm of a free slot is only acknowledged
      '{'{OP_ARM, 5'd5, 8'h00, 32'h0, 32'd1, 1'b0}, 1'b1, KIND_ACK, 5'd0, 1'b0},
      '{'{OP_TICK, 5'd0, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b0, KIND_ACK, 5'd0, 1'b0},
      '{'{OP_TICK, 5'd0, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b0, KIND_ACK, 5'd0, 1'b0},
      // deadline wraps below the count
      '{'{OP_ARM, 5'd0, 8'h00, 32'h0, 32'hffffffff, 1'b0}, 1'b0, KIND_ACK, 5'd0, 1'b0},
      // re-arm of a running slot
      '{'{OP_ARM, 5'd0, 8'h00, 32'h0, 32'd5, 1'b0}, 1'b0, KIND_ACK, 5'd0, 1'b0},
      '{'{OP_SET_MARK, 5'd0, 8'h00, 32'h0, 32'h0, 1'b1}, 1'b1, KIND_ACK, 5'd0, 1'b0},
      '{'{OP_CANCEL_ALL, 5'd0, 8'hff, 32'h0, 32'h0, 1'b0}, 1'b1, KIND_ACK, 5'd0, 1'b0},
      '{'{OP_CANCEL, 5'd0, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b1, KIND_CANCEL, 5'd0, 1'b0},
      '{'{OP_ARM, 5'd1, 8'h00, 32'h0, 32'd0, 1'b0}, 1'b0, KIND_ACK, 5'd0, 1'b0},
      '{'{OP_CANCEL, 5'd1, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b1, KIND_CANCEL, 5'd1, 1'b1},
      '{'{OP_FREE, 5'd1, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b1, KIND_ACK, 5'd0, 1'b0},
      '{'{OP_FREE, 5'd31, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b1, KIND_ACK, 5'd0, 1'b0},
      '{'{OP_SET_MARK, 5'd31, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b1, KIND_ACK, 5'd0, 1'b0},
      '{'{OP_ALLOC, 5'd0, 8'h00, 32'h0, 32'h0, 1'b0}, 1'b1, KIND_ALLOC, 5'd0, 1'b1}
    };
    task_slots = '{6'd0, 6'd31, 6'd63, 6'd5, TTS_RESET};
    tx_modes = '{0, 75, 0, 22, 0};
    rx_modes = '{0, 0, 75, 22, 0};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd);
      if (dir_rows[i].typed) begin
        r = pending_results.pop_back();
        push_result(dir_rows[i].kind, dir_rows[i].slot, dir_rows[i].ok, 8'd0, 32'd0,
                    1'b0, 1'b1);
      end
    end
    drain_results();

    // random phases, each with its own task slot and an idling pattern
    for (int p = 0; p < 5; p++) begin
      write_task_slot(task_slots[p]);
      tx_idle_pct = tx_modes[p];
      rx_stall_pct = rx_modes[p];
      // exhaust the pool once
      if (p == 1) begin
        c = random_timer_cmd();
        c.op = OP_ALLOC;
        repeat (33) send_cmd(c);
      end
      for (int n = 0; n < 31; n++) begin
        if (p == 4 && n == 10) hold_req = 1'b1;
        // sender waits for everything outstanding
        if (p == 4 && n == 25) drain_results();
        send_cmd(random_timer_cmd());
      end
      drain_results();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb_sorted_timer_queue: PASS");
    else $display("tb_sorted_timer_queue: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/stq_pkg.sv
rtl/stq_datapath.sv
rtl/stq_ctrl.sv
rtl/sorted_timer_queue.sv
rtl/stq_checker.sv
dv/tb_sorted_timer_queue.sv
